@@ hdl/assert_macros.svh @@
// assertion macros used by the page table engine back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk_i, quiet while rst_ni is low
`define TPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpt assertion failed");

// same check written as condition and consequence
`define TPT_IMPLIES(lbl, a, b) `TPT_ASSERT(lbl, (a) |-> (b))

`endif

@@ hdl/tpt_pkg.sv @@
// types, sizes and codes of the two-level page table engine
`default_nettype none
package tpt_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_SLOTS   = 16;

  localparam int DIR_W   = $clog2(DIR_ENTRIES);
  localparam int TBL_W   = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int ENT_AW  = SLOT_W + TBL_W;
  localparam int ENT_DEPTH = 1 << ENT_AW;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int P_W     = 21;
  localparam int TOTAL_PAGES = DIR_ENTRIES * TABLE_ENTRIES;
  localparam int ENT_W   = 28;
  localparam int QDEPTH  = 2;
  localparam int Q_AW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    FN_MAP    = 2'd0,
    FN_UNMAP  = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_FIND   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_MISAL  = 2'd1,
    STS_NOSLOT = 2'd2,
    STS_NORUN  = 2'd3
  } status_e;

  typedef struct packed {
    func_e              func;
    logic               misal;
    logic               dir_oor;
    logic [DIR_W-1:0]   dir_idx;
    logic [TBL_W-1:0]   tbl_idx;
    logic [19:0]        frame;
    logic [7:0]         flags;
    logic [P_W-1:0]     lo_p;
    logic [P_W-1:0]     hi_p;
    logic [P_W-1:0]     need;
  } q_item_t;

  typedef struct packed {
    status_e     status;
    logic        present;
    logic [31:0] addr;
  } res_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage
`default_nettype wire

@@ hdl/tpt_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ hdl/tpt_front.sv @@
// front end: accepts words, decodes them and queues them for the back end
`default_nettype none
module tpt_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          in_func_i,
  input  wire logic [31:0]         in_phys_i,
  input  wire logic [31:0]         in_virt_i,
  input  wire logic [31:0]         in_high_i,
  input  wire logic [7:0]          in_flags_i,
  input  wire logic [20:0]         in_count_i,
  input  wire tpt_pkg::back_stat_t stat_i,
  output logic                     q_valid_o,
  input  wire logic                q_ready_i,
  output tpt_pkg::q_item_t         q_item_o
);
  import tpt_pkg::*;

  q_item_t         item;
  q_item_t         mem_q [QDEPTH];
  logic [Q_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_AW:0]   cnt_q, cnt_d;
  logic [P_W-1:0]  vpn_full, hi_full;
  logic            push, pop;

  always_comb begin
    vpn_full      = P_W'(in_virt_i[31:12]);
    hi_full       = P_W'(in_high_i[31:12]);
    item.func     = func_e'(in_func_i);
    item.misal    = (in_phys_i[11:0] != 12'h000) || (in_virt_i[11:0] != 12'h000);
    item.dir_oor  = (vpn_full >> TBL_W) >= P_W'(DIR_ENTRIES);
    item.dir_idx  = DIR_W'(vpn_full >> TBL_W);
    item.tbl_idx  = vpn_full[TBL_W-1:0];
    item.frame    = in_phys_i[31:12];
    item.flags    = in_flags_i | 8'h01;
    item.lo_p     = vpn_full;
    item.hi_p     = (hi_full > P_W'(TOTAL_PAGES)) ? P_W'(TOTAL_PAGES) : hi_full;
    item.need     = (in_count_i == 21'd0) ? P_W'(1) : P_W'(in_count_i);
  end

  assign in_ready_o = (cnt_q < (Q_AW + 1)'(QDEPTH)) && !stat_i.clearing;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != '0;
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + Q_AW'(1) : wr_q;
    rd_d  = pop ? rd_q + Q_AW'(1) : rd_q;
    cnt_d = cnt_q + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end
endmodule
`default_nettype wire

@@ hdl/tpt_back.sv @@
// back end: walks directory and table memories and builds results
`default_nettype none
`include "assert_macros.svh"
module tpt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  output logic                  q_ready_o,
  input  wire tpt_pkg::q_item_t q_item_i,
  output tpt_pkg::back_stat_t   stat_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output tpt_pkg::res_t         out_o
);
  import tpt_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DRD  = 4'd2;
  localparam logic [3:0] S_DUSE = 4'd3;
  localparam logic [3:0] S_MCLR = 4'd4;
  localparam logic [3:0] S_ERD  = 4'd5;
  localparam logic [3:0] S_EUSE = 4'd6;
  localparam logic [3:0] S_FD   = 4'd7;
  localparam logic [3:0] S_FDW  = 4'd8;
  localparam logic [3:0] S_FE   = 4'd9;
  localparam logic [3:0] S_FEW  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]        state_q, state_d;
  q_item_t           op_q, op_d;
  res_t              res_q, res_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [DIR_W-1:0]  clr_q, clr_d;
  logic [TBL_W-1:0]  idx_q, idx_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [P_W-1:0]    p_q, p_d, run_q, run_d, start_q, start_d, tend_q, tend_d;
  logic [TABLE_SLOTS-1:0] busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q [TABLE_SLOTS];
  logic [CNT_W-1:0]  cnt_d [TABLE_SLOTS];

  logic              dir_we;
  logic [DIR_W-1:0]  dir_addr;
  logic [SLOT_W:0]   dir_wdata, dir_rdata;
  logic              ent_we;
  logic [ENT_AW-1:0] ent_addr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;

  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [P_W-1:0]    bound, run_new, start_new, p_next;

  tpt_ram #(.WIDTH(SLOT_W + 1), .DEPTH(DIR_ENTRIES)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .addr_i  (dir_addr),
    .wdata_i (dir_wdata),
    .rdata_o (dir_rdata)
  );

  tpt_ram #(.WIDTH(ENT_W), .DEPTH(ENT_DEPTH)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .addr_i  (ent_addr),
    .wdata_i (ent_wdata),
    .rdata_o (ent_rdata)
  );

  // lowest free slot in the pool
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    clr_d       = clr_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    p_d         = p_q;
    run_d       = run_q;
    start_d     = start_q;
    tend_d      = tend_q;
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    q_ready_o   = 1'b0;
    dir_we      = 1'b0;
    dir_addr    = op_q.dir_idx;
    dir_wdata   = '0;
    ent_we      = 1'b0;
    ent_addr    = {slot_q, op_q.tbl_idx};
    ent_wdata   = '0;
    // end of the current table's span; S_FD clips it to the search limit
    bound       = {p_q[P_W-1:TBL_W] + (P_W - TBL_W)'(1), TBL_W'(0)};
    run_new     = '0;
    start_new   = start_q;
    p_next      = p_q + P_W'(1);

    case (state_q)
      S_CLR: begin
        dir_we   = 1'b1;
        dir_addr = clr_q;
        clr_d    = clr_q + DIR_W'(1);
        if (clr_q == DIR_W'(DIR_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          op_d  = q_item_i;
          res_d = '{status: STS_OK, present: 1'b0, addr: 32'h0};
          if (q_item_i.func == FN_FIND) begin
            p_d     = q_item_i.lo_p;
            run_d   = '0;
            start_d = '0;
            state_d = S_FD;
          end else if (q_item_i.func == FN_MAP && q_item_i.misal) begin
            res_d.status = STS_MISAL;
            state_d      = S_DONE;
          end else if (q_item_i.dir_oor) begin
            if (q_item_i.func == FN_MAP) begin
              res_d.status = STS_NOSLOT;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_DRD;
          end
        end
      end
      S_DRD: begin
        state_d = S_DUSE;
      end
      S_DUSE: begin
        if (dir_rdata[SLOT_W]) begin
          slot_d  = dir_rdata[SLOT_W-1:0];
          state_d = S_ERD;
        end else if (op_q.func != FN_MAP) begin
          state_d = S_DONE;
        end else if (!free_found) begin
          res_d.status = STS_NOSLOT;
          state_d      = S_DONE;
        end else begin
          slot_d            = free_slot;
          busy_d[free_slot] = 1'b1;
          cnt_d[free_slot]  = '0;
          dir_we            = 1'b1;
          dir_wdata         = {1'b1, free_slot};
          idx_d             = '0;
          state_d           = S_MCLR;
        end
      end
      S_MCLR: begin
        ent_we   = 1'b1;
        ent_addr = {slot_q, idx_q};
        idx_d    = idx_q + TBL_W'(1);
        if (idx_q == TBL_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        state_d = S_EUSE;
      end
      S_EUSE: begin
        state_d = S_DONE;
        case (op_q.func)
          FN_MAP: begin
            ent_we    = 1'b1;
            ent_wdata = {op_q.frame, op_q.flags};
            if (ent_rdata == '0) begin
              cnt_d[slot_q] = cnt_q[slot_q] + CNT_W'(1);
            end
          end
          FN_UNMAP: begin
            ent_we = 1'b1;
            if (ent_rdata != '0) begin
              cnt_d[slot_q] = cnt_q[slot_q] - CNT_W'(1);
              // last live entry gone: release the table
              if (cnt_q[slot_q] == CNT_W'(1)) begin
                busy_d[slot_q] = 1'b0;
                dir_we         = 1'b1;
              end
            end
          end
          default: begin
            res_d.present = ent_rdata[0];
            res_d.addr    = {ent_rdata[27:8], 12'h000};
          end
        endcase
      end
      S_FD: begin
        dir_addr = DIR_W'(p_q >> TBL_W);
        tend_d   = (bound > op_q.hi_p) ? op_q.hi_p : bound;
        if (p_q >= op_q.hi_p) begin
          res_d.status = STS_NORUN;
          state_d      = S_DONE;
        end else begin
          state_d = S_FDW;
        end
      end
      S_FDW: begin
        if (dir_rdata[SLOT_W]) begin
          slot_d  = dir_rdata[SLOT_W-1:0];
          state_d = S_FE;
        end else begin
          // absent table: the whole span counts as free
          if (run_q == '0) begin
            start_new = p_q;
          end
          run_new = run_q + (tend_q - p_q);
          start_d = start_new;
          run_d   = run_new;
          p_d     = tend_q;
          if (run_new >= op_q.need) begin
            res_d.addr = {start_new[19:0], 12'h000};
            state_d    = S_DONE;
          end else begin
            state_d = S_FD;
          end
        end
      end
      S_FE: begin
        ent_addr = {slot_q, p_q[TBL_W-1:0]};
        state_d  = S_FEW;
      end
      S_FEW: begin
        p_d = p_next;
        if (ent_rdata[0]) begin
          run_d = '0;
        end else begin
          if (run_q == '0) begin
            start_new = p_q;
          end
          run_new = run_q + P_W'(1);
          start_d = start_new;
          run_d   = run_new;
        end
        if (!ent_rdata[0] && run_new >= op_q.need) begin
          res_d.addr = {start_new[19:0], 12'h000};
          state_d    = S_DONE;
        end else if (p_next >= tend_q) begin
          state_d = S_FD;
        end else begin
          state_d = S_FE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      busy_q      <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    res_q   <= res_d;
    out_q   <= out_d;
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    p_q     <= p_d;
    run_q   <= run_d;
    start_q <= start_d;
    tend_q  <= tend_d;
  end

  assign stat_o.clearing = (state_q == S_CLR);
  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;

  `TPT_IMPLIES(a_clr_no_out, state_q == S_CLR, !out_valid_q)
  `TPT_IMPLIES(a_present_ok, out_valid_q && out_q.present, out_q.status == STS_OK)
  `TPT_IMPLIES(a_scan_short, state_q == S_FE || state_q == S_FD, run_q < op_q.need)
endmodule
`default_nettype wire

@@ hdl/two_level_page_table_engine_top.sv @@
// top level of the two-level page table engine
//
// channel   dir  tdata bits (lowest first)                          tuser
// s_axis    in   frame_addr 32, virt_addr 32, search_high 32,       func 2
//                map_flags 8, page_count 21, pad 3
// m_axis    out  present 1, result_addr 32, pad 7                   status 2
//
// after reset the directory memory is swept, one entry a cycle,
// and no word is taken until the sweep ends
// lookup, unmap and a map into an existing table read the directory, then read and use the entry
// a map that creates a table first clears all of its entries
// find passes over an absent table's whole span at once and checks a present table page by page
// a two-word queue lets input be taken while the back end works or stalls
`default_nettype none
module two_level_page_table_engine_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // frame_addr, virt_addr, search_high, map_flags, page_count
  input  wire logic [127:0] s_axis_tdata_i,
  // func
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // present, result_addr
  output logic [39:0]       m_axis_tdata_o,
  // status
  output logic [1:0]        m_axis_tuser_o
);
  import tpt_pkg::*;

  back_stat_t stat;
  q_item_t    q_item;
  logic       q_valid, q_ready;
  res_t       res;

  tpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_func_i  (s_axis_tuser_i),
    .in_phys_i  (s_axis_tdata_i[31:0]),
    .in_virt_i  (s_axis_tdata_i[63:32]),
    .in_high_i  (s_axis_tdata_i[95:64]),
    .in_flags_i (s_axis_tdata_i[103:96]),
    .in_count_i (s_axis_tdata_i[124:104]),
    .stat_i     (stat),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  tpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {7'b0, res.addr, res.present};
  assign m_axis_tuser_o = res.status;
endmodule
`default_nettype wire
